// ----- hw/rtl/short_name_builder_defines.svh -----
// Assertion macros shared by the short name builder checker.
`ifndef SHORT_NAME_BUILDER_DEFINES_SVH
`define SHORT_NAME_BUILDER_DEFINES_SVH

// Property that must hold in the same cycle once the antecedent is true.
`define SNB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Property that must hold in the cycle after the antecedent is true.
`define SNB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/snb_pkg.sv -----
// Types and constants of the short name builder.
package snb_pkg;

	localparam int BASE_LEN = 8;
	localparam int EXT_LEN = 3;
	localparam int BASE_CNT_W = 4;
	localparam int EXT_CNT_W = 2;

	localparam logic [7:0] SPACE_CODE = 8'h20;
	localparam logic [7:0] FIRST_PRINTABLE = 8'd33;
	localparam logic [7:0] DOT_CODE = 8'h2E;
	localparam logic [7:0] SLASH_CODE = 8'h2F;
	localparam logic [7:0] BSLASH_CODE = 8'h5C;
	localparam logic [7:0] LOWER_A = 8'h61;
	localparam logic [7:0] LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam logic [63:0] BASE_SPACES = 64'h2020_2020_2020_2020;
	localparam logic [23:0] EXT_SPACES = 24'h20_2020;

	typedef struct packed {
		logic [7:0] char_code;
		logic last_char;
	} char_word_t;

	typedef struct packed {
		logic [63:0] name_base;
		logic [23:0] name_ext;
		logic name_ok;
	} name_word_t;

	typedef struct packed {
		logic [7:0] ch;
		logic is_dot;
		logic is_bad;
	} char_class_t;

endpackage

// ----- hw/rtl/snb_char_class.sv -----
// Case raising and classification of one path character.
module snb_char_class (
	input logic [7:0] char_code,
	output snb_pkg::char_class_t cls
);

	logic [7:0] ch;

	always_comb begin
		if (char_code >= snb_pkg::LOWER_A && char_code <= snb_pkg::LOWER_Z) begin
			ch = char_code - snb_pkg::CASE_OFFSET;
		end else begin
			ch = char_code;
		end
	end

	// Bytes with the top bit set count as negative signed chars and are rejected.
	assign cls.ch = ch;
	assign cls.is_dot = (ch == snb_pkg::DOT_CODE);
	assign cls.is_bad = (ch == snb_pkg::SLASH_CODE) || (ch == snb_pkg::SPACE_CODE) ||
		(ch == snb_pkg::BSLASH_CODE) || (ch < snb_pkg::FIRST_PRINTABLE) || ch[7];

endmodule

// ----- hw/rtl/snb_name_acc.sv -----
// Name accumulator: base and extension bytes, counts and error flag.
module snb_name_acc (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic last_char,
	input snb_pkg::char_class_t cls,
	output snb_pkg::name_word_t result
);

	logic [63:0] base_q, base_nx;
	logic [23:0] ext_q, ext_nx;
	logic [snb_pkg::BASE_CNT_W-1:0] base_cnt_q, base_cnt_nx;
	logic [snb_pkg::EXT_CNT_W-1:0] ext_cnt_q, ext_cnt_nx;
	logic in_ext_q, in_ext_nx;
	logic failed_q, failed_nx;
	logic ok;

	always_comb begin
		base_nx = base_q;
		ext_nx = ext_q;
		base_cnt_nx = base_cnt_q;
		ext_cnt_nx = ext_cnt_q;
		in_ext_nx = in_ext_q;
		failed_nx = failed_q;
		if (!failed_q) begin
			if (cls.is_dot) begin
				if (in_ext_q) begin
					failed_nx = 1'b1;
				end else begin
					in_ext_nx = 1'b1;
				end
			end else if (cls.is_bad) begin
				failed_nx = 1'b1;
			end else if (!in_ext_q) begin
				if (base_cnt_q >= snb_pkg::BASE_CNT_W'(snb_pkg::BASE_LEN)) begin
					failed_nx = 1'b1;
				end else begin
					for (int i = 0; i < snb_pkg::BASE_LEN; i++) begin
						if (base_cnt_q[2:0] == 3'(i)) begin
							base_nx[8*i +: 8] = cls.ch;
						end
					end
					base_cnt_nx = base_cnt_q + 1'b1;
				end
			end else begin
				if (ext_cnt_q == snb_pkg::EXT_CNT_W'(snb_pkg::EXT_LEN)) begin
					failed_nx = 1'b1;
				end else begin
					for (int i = 0; i < snb_pkg::EXT_LEN; i++) begin
						if (ext_cnt_q == snb_pkg::EXT_CNT_W'(i)) begin
							ext_nx[8*i +: 8] = cls.ch;
						end
					end
					ext_cnt_nx = ext_cnt_q + 1'b1;
				end
			end
		end
	end

	// A rejected name is reported with both name fields cleared.
	assign ok = !failed_nx && (base_cnt_nx != '0);
	assign result.name_base = ok ? base_nx : '0;
	assign result.name_ext = ok ? ext_nx : '0;
	assign result.name_ok = ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= snb_pkg::BASE_SPACES;
			ext_q <= snb_pkg::EXT_SPACES;
			base_cnt_q <= '0;
			ext_cnt_q <= '0;
			in_ext_q <= 1'b0;
			failed_q <= 1'b0;
		end else if (step) begin
			if (last_char) begin
				base_q <= snb_pkg::BASE_SPACES;
				ext_q <= snb_pkg::EXT_SPACES;
				base_cnt_q <= '0;
				ext_cnt_q <= '0;
				in_ext_q <= 1'b0;
				failed_q <= 1'b0;
			end else begin
				base_q <= base_nx;
				ext_q <= ext_nx;
				base_cnt_q <= base_cnt_nx;
				ext_cnt_q <= ext_cnt_nx;
				in_ext_q <= in_ext_nx;
				failed_q <= failed_nx;
			end
		end
	end

endmodule

// ----- hw/rtl/short_name_builder.sv -----
// Top level of the FAT 8.3 short name builder.
//
// The char channel (char_valid, char_stall, char_word) takes one byte of a
// path component per word; last_char marks the final byte of the component.
// The name channel (name_valid, name_stall, name_word) gives one word per
// component: the space padded base and extension and an ok flag. A rejected
// component gives name_ok low with both name fields zero.
// A character word lands in an input register; from there its effect is
// folded into the name registers and, for the final byte, the finished name
// is loaded into the output register. The name word is therefore visible once
// the final byte has left the input register, which char_stall can delay.
// Throughput is one character word per cycle while char_stall is low, set by
// the single pass from the input register through the accumulator logic.
// While a finished name waits under name_stall, characters of the next
// component keep flowing; char_stall rises only when a further final byte
// reaches the input register while the output register is held by name_stall.
// Reset clears the pipeline and starts a fresh component with no name held.
module short_name_builder (
	input logic clk,
	input logic arst_n,
	input logic char_valid,
	output logic char_stall,
	input snb_pkg::char_word_t char_word,
	output logic name_valid,
	input logic name_stall,
	output snb_pkg::name_word_t name_word
);

	logic valid_s1;
	snb_pkg::char_word_t word_s1;
	logic adv;
	snb_pkg::char_class_t cls;
	snb_pkg::name_word_t result;
	logic out_valid_q;
	snb_pkg::name_word_t out_word_q;

	// The staged byte moves on unless it would produce a name into a full,
	// stalled output register.
	assign char_stall = valid_s1 && word_s1.last_char && out_valid_q && name_stall;
	assign adv = valid_s1 && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid) begin
			word_s1 <= char_word;
		end
	end

	snb_char_class u_class (
		.char_code(word_s1.char_code),
		.cls(cls)
	);

	snb_name_acc u_acc (
		.clk(clk),
		.arst_n(arst_n),
		.step(adv),
		.last_char(word_s1.last_char),
		.cls(cls),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && word_s1.last_char) begin
			out_valid_q <= 1'b1;
		end else if (!name_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && word_s1.last_char) begin
			out_word_q <= result;
		end
	end

	assign name_valid = out_valid_q;
	assign name_word = out_word_q;

endmodule

// ----- hw/rtl/snb_checker.sv -----
// Port checker for the short name builder, bound to the top level.
`include "short_name_builder_defines.svh"

module snb_checker (
	input logic clk,
	input logic arst_n,
	input logic char_valid,
	input logic char_stall,
	input snb_pkg::char_word_t char_word,
	input logic name_valid,
	input logic name_stall,
	input snb_pkg::name_word_t name_word
);

	`SNB_ASSERT_NEXT(a_name_hold, clk, arst_n, name_valid && name_stall,
		name_valid && $stable(name_word), "name word changed while stalled")
	`SNB_ASSERT_NEXT(a_char_hold, clk, arst_n, char_valid && char_stall,
		char_valid && $stable(char_word), "char word changed while stalled")
	`SNB_ASSERT_SAME(a_reject_zero, clk, arst_n, name_valid && !name_word.name_ok,
		name_word.name_base == '0 && name_word.name_ext == '0, "rejected name carries data")
	`SNB_ASSERT_SAME(a_base_filled, clk, arst_n, name_valid && name_word.name_ok,
		name_word.name_base[7:0] != snb_pkg::SPACE_CODE, "accepted name has an empty base")
	`SNB_ASSERT_SAME(a_stall_cause, clk, arst_n, char_stall,
		name_valid && name_stall, "char stall without a blocked name")

endmodule

bind short_name_builder snb_checker u_snb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.char_valid(char_valid),
	.char_stall(char_stall),
	.char_word(char_word),
	.name_valid(name_valid),
	.name_stall(name_stall),
	.name_word(name_word)
);

// ----- bench/short_name_checker.sv -----
// Checker for the short name builder: predicts each name word and compares it.
`timescale 1ns / 1ps

module short_name_checker (
	input logic clk,
	input logic arst_n,
	input logic char_valid,
	input logic char_stall,
	input snb_pkg::char_word_t char_word,
	input logic name_valid,
	input logic name_stall,
	input snb_pkg::name_word_t name_word,
	output int fail_count,
	output int names_pending
);

	logic [63:0] base_acc;
	logic [23:0] ext_acc;
	logic [3:0] base_fill;
	logic [1:0] ext_fill;
	logic ext_mode;
	logic rejected;
	snb_pkg::name_word_t expected_names[$];

	task automatic clear_name();
		base_acc = snb_pkg::BASE_SPACES;
		ext_acc = snb_pkg::EXT_SPACES;
		base_fill = '0;
		ext_fill = '0;
		ext_mode = 1'b0;
		rejected = 1'b0;
	endtask

	task automatic fold_char(input logic [7:0] code);
		logic [7:0] ch;
		ch = (code >= snb_pkg::LOWER_A && code <= snb_pkg::LOWER_Z) ?
			code - snb_pkg::CASE_OFFSET : code;
		if (rejected)
			return;
		if (ch == snb_pkg::DOT_CODE) begin
			if (ext_mode)
				rejected = 1'b1;
			else
				ext_mode = 1'b1;
			return;
		end
		// Bytes of 128 and up count as negative signed chars and are refused.
		if (ch == snb_pkg::SLASH_CODE || ch == snb_pkg::BSLASH_CODE ||
				ch == snb_pkg::SPACE_CODE || ch < snb_pkg::FIRST_PRINTABLE || ch[7]) begin
			rejected = 1'b1;
			return;
		end
		if (!ext_mode) begin
			if (base_fill >= snb_pkg::BASE_LEN) begin
				rejected = 1'b1;
				return;
			end
			base_acc[base_fill * 8 +: 8] = ch;
			base_fill = base_fill + 1'b1;
		end else begin
			if (ext_fill >= snb_pkg::EXT_LEN) begin
				rejected = 1'b1;
				return;
			end
			ext_acc[ext_fill * 8 +: 8] = ch;
			ext_fill = ext_fill + 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		snb_pkg::name_word_t want;
		snb_pkg::name_word_t made;
		if (!arst_n) begin
			clear_name();
			expected_names.delete();
			fail_count = 0;
			names_pending = 0;
		end else begin
			// A name word always trails its final byte, so check it before folding.
			if (name_valid && !name_stall) begin
				if (expected_names.size() == 0) begin
					$display("%0t: unexpected name word: expected none, actual %h",
						$time, name_word);
					fail_count++;
				end else begin
					want = expected_names.pop_front();
					if (name_word.name_base !== want.name_base) begin
						$display("%0t: name_base expected %h actual %h",
							$time, want.name_base, name_word.name_base);
						fail_count++;
					end
					if (name_word.name_ext !== want.name_ext) begin
						$display("%0t: name_ext expected %h actual %h",
							$time, want.name_ext, name_word.name_ext);
						fail_count++;
					end
					if (name_word.name_ok !== want.name_ok) begin
						$display("%0t: name_ok expected %b actual %b",
							$time, want.name_ok, name_word.name_ok);
						fail_count++;
					end
				end
			end
			if (char_valid && !char_stall) begin
				fold_char(char_word.char_code);
				if (char_word.last_char) begin
					if (!rejected && base_fill != 0) begin
						made.name_base = base_acc;
						made.name_ext = ext_acc;
						made.name_ok = 1'b1;
					end else begin
						made = '0;
					end
					expected_names.push_back(made);
					clear_name();
				end
			end
			names_pending = expected_names.size();
		end
	end

endmodule

// ----- bench/testbench.sv -----
// Top of the short name builder bench: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module testbench;

	localparam int RANDOM_CHARS = 2000;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n;
	logic char_valid;
	logic char_stall;
	snb_pkg::char_word_t char_word;
	logic name_valid;
	logic name_stall;
	snb_pkg::name_word_t name_word;

	int fail_count;
	int names_pending;
	int chars_sent;
	int idle_cycles;
	logic tail_quiet;
	logic [7:0] comp_chars[$];

	short_name_builder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_word(char_word),
		.name_valid(name_valid),
		.name_stall(name_stall),
		.name_word(name_word)
	);

	short_name_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_word(char_word),
		.name_valid(name_valid),
		.name_stall(name_stall),
		.name_word(name_word),
		.fail_count(fail_count),
		.names_pending(names_pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Count cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (!arst_n || (char_valid && !char_stall) || (name_valid && !name_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (arst_n === 1'b1);
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	// Receiver side: random stall bursts until the quiet tail of the run.
	initial begin
		name_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!tail_quiet && $urandom_range(0, 7) == 0) begin
				name_stall = 1'b1;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				name_stall = 1'b0;
			end
		end
	end

	task automatic send_char(input logic [7:0] code, input logic last);
		@(negedge clk);
		if (!tail_quiet && $urandom_range(0, 9) == 0) begin
			char_valid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		char_valid = 1'b1;
		char_word.char_code = code;
		char_word.last_char = last;
		do
			@(posedge clk);
		while (char_stall);
		chars_sent++;
	endtask

	task automatic send_comp();
		int n;
		n = comp_chars.size();
		for (int i = 0; i < n; i++)
			send_char(comp_chars[i], i == n - 1);
		comp_chars.delete();
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			comp_chars.push_back(s[i]);
		send_comp();
	endtask

	// Hold the char side off until every name word has been taken.
	task automatic drain_pause();
		@(negedge clk);
		char_valid = 1'b0;
		while (names_pending != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] name_char();
		logic [7:0] ch;
		do
			ch = 8'($urandom_range(33, 127));
		while (ch == snb_pkg::DOT_CODE || ch == snb_pkg::SLASH_CODE ||
			ch == snb_pkg::BSLASH_CODE);
		return ch;
	endfunction

	function automatic logic [7:0] bad_char();
		case ($urandom_range(0, 5))
			0: return snb_pkg::SLASH_CODE;
			1: return snb_pkg::BSLASH_CODE;
			2: return snb_pkg::SPACE_CODE;
			3: return 8'($urandom_range(0, 32));
			4: return 8'($urandom_range(128, 255));
			default: return snb_pkg::DOT_CODE;
		endcase
	endfunction

	task automatic build_wellformed();
		int base_n;
		int ext_n;
		base_n = ($urandom_range(0, 15) == 0) ? 9 : $urandom_range(1, 8);
		for (int i = 0; i < base_n; i++)
			comp_chars.push_back(name_char());
		if ($urandom_range(0, 3) != 0) begin
			comp_chars.push_back(snb_pkg::DOT_CODE);
			ext_n = ($urandom_range(0, 15) == 0) ? 4 : $urandom_range(0, 3);
			for (int i = 0; i < ext_n; i++)
				comp_chars.push_back(name_char());
		end
	endtask

	initial begin
		int kind;
		int n;
		arst_n = 1'b0;
		char_valid = 1'b0;
		char_word = '0;
		tail_quiet = 1'b0;
		chars_sent = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed words: case raising, dots, refused bytes and length limits.
		send_text("z");
		send_text(".");
		send_text("..");
		send_text(".x");
		comp_chars.push_back(8'hFF);
		send_comp();
		comp_chars.push_back(8'h00);
		send_comp();
		comp_chars.push_back(8'h7F);
		send_comp();
		send_text("!");
		send_text("/");
		send_text("\\");
		send_text(" ");
		send_text("A.bcde");
		send_text("abcdefghi");
		drain_pause();

		while (chars_sent < RANDOM_CHARS) begin
			if (chars_sent > RANDOM_CHARS * 9 / 10)
				tail_quiet = 1'b1;
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				build_wellformed();
			end else if (kind == 7) begin
				build_wellformed();
				comp_chars[$urandom_range(0, comp_chars.size() - 1)] = bad_char();
			end else begin
				n = $urandom_range(1, 10);
				for (int i = 0; i < n; i++)
					case ($urandom_range(0, 3))
						0: comp_chars.push_back(8'($urandom_range(0, 255)));
						1: comp_chars.push_back(bad_char());
						default: comp_chars.push_back(name_char());
					endcase
			end
			send_comp();
			if ($urandom_range(0, 99) == 0)
				drain_pause();
		end

		@(negedge clk);
		char_valid = 1'b0;
		while (names_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
